FILE: design/dvr_pkg.sv
// ---------------------------------------------------------------------------
// dvr_pkg - shared types and constants for the dual-axis velocity ramp
// Field widths, configuration register indexes and the per-axis limit pair.
// ---------------------------------------------------------------------------
package dvr_pkg;

  // Field widths
  localparam int VEL_W   = 32;   // signed Q16.16 velocity
  localparam int LIMIT_W = 31;   // unsigned Q15.16 per second
  localparam int TICK_W  = 16;   // unsigned Q0.16 seconds
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIN_ACCEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_DECEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_ACCEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_DECEL = 2'd3;

  // Acceleration / deceleration limits of one axis
  typedef struct packed {
    logic [LIMIT_W-1:0] accel;
    logic [LIMIT_W-1:0] decel;
  } limits_t;

endpackage

FILE: design/dvr_cfg_regs.sv
// ---------------------------------------------------------------------------
// dvr_cfg_regs - limit register file
// Holds the four acceleration / deceleration limits written over the
// configuration channel. Always ready; values keep their low 31 bits.
// ---------------------------------------------------------------------------
module dvr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dvr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dvr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dvr_pkg::limits_t                lin_limits,
  output dvr_pkg::limits_t                ang_limits
);

  dvr_pkg::limits_t lin_limits_r, lin_limits_nxt;
  dvr_pkg::limits_t ang_limits_r, ang_limits_nxt;
  logic [dvr_pkg::LIMIT_W-1:0] wr_value;

  assign cfg_ready = 1'b1;
  assign wr_value  = cfg_data[dvr_pkg::LIMIT_W-1:0];

  // Register write decode
  always_comb begin
    lin_limits_nxt = lin_limits_r;
    ang_limits_nxt = ang_limits_r;
    if (cfg_valid) begin
      case (cfg_index)
        dvr_pkg::REG_LIN_ACCEL: lin_limits_nxt.accel = wr_value;
        dvr_pkg::REG_LIN_DECEL: lin_limits_nxt.decel = wr_value;
        dvr_pkg::REG_ANG_ACCEL: ang_limits_nxt.accel = wr_value;
        dvr_pkg::REG_ANG_DECEL: ang_limits_nxt.decel = wr_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_limits_r <= '0;
      ang_limits_r <= '0;
    end else begin
      lin_limits_r <= lin_limits_nxt;
      ang_limits_r <= ang_limits_nxt;
    end
  end

  assign lin_limits = lin_limits_r;
  assign ang_limits = ang_limits_r;

endmodule

FILE: design/dvr_axis.sv
// ---------------------------------------------------------------------------
// dvr_axis - ramp step of one axis
// Restart-from-measurement rule, accel/decel step of limit * dt, clamp at
// the target and saturation to the signed 32-bit range. Combinational.
// ---------------------------------------------------------------------------
module dvr_axis (
  input  logic signed [dvr_pkg::VEL_W-1:0]  tgt,
  input  logic signed [dvr_pkg::VEL_W-1:0]  meas,
  input  logic signed [dvr_pkg::VEL_W-1:0]  ramp,
  input  dvr_pkg::limits_t                  limits,
  input  logic        [dvr_pkg::TICK_W-1:0] dt,
  output logic signed [dvr_pkg::VEL_W-1:0]  ramp_out
);

  localparam int DW = dvr_pkg::VEL_W + 1;   // difference width
  localparam int RW = dvr_pkg::VEL_W + 2;   // ramp arithmetic width
  localparam int PW = dvr_pkg::LIMIT_W + dvr_pkg::TICK_W;
  localparam logic signed [RW-1:0] SAT_MAX = RW'(64'sd2147483647);
  localparam logic signed [RW-1:0] SAT_MIN = -RW'(64'sd2147483648);

  logic signed [DW-1:0] d_mr, d_tr, d_tm;
  logic                 snap, dir_pos, dir_neg, accel;
  logic [dvr_pkg::LIMIT_W-1:0] lim_sel;
  logic [PW-1:0]               prod;
  logic [dvr_pkg::LIMIT_W-1:0] step;
  logic signed [RW-1:0] ramp0, tgt_x, step_x, ramp1, ramp2;
  logic                 clamp;

  // Direction tests on exact differences
  assign d_mr = DW'(meas) - DW'(ramp);
  assign d_tr = DW'(tgt)  - DW'(ramp);
  assign d_tm = DW'(tgt)  - DW'(meas);

  assign snap    = ((d_mr > 0) && (d_tr > 0)) || ((d_mr < 0) && (d_tr < 0));
  assign dir_pos = d_tm > 0;
  assign dir_neg = d_tm < 0;

  // Speed magnitude grows (or measurement zero): use the accel limit
  assign accel = (meas == '0) || (!dir_pos && !dir_neg) ||
                 (dir_pos && !meas[dvr_pkg::VEL_W-1]) ||
                 (dir_neg &&  meas[dvr_pkg::VEL_W-1]);

  assign lim_sel = accel ? limits.accel : limits.decel;
  assign prod    = PW'(lim_sel) * PW'(dt);
  assign step    = prod[PW-1:dvr_pkg::TICK_W];

  // Step toward the target from the (possibly restarted) ramp
  assign ramp0  = snap ? RW'(meas) : RW'(ramp);
  assign tgt_x  = RW'(tgt);
  assign step_x = RW'({1'b0, step});

  always_comb begin
    if (dir_pos)      ramp1 = ramp0 + step_x;
    else if (dir_neg) ramp1 = ramp0 - step_x;
    else              ramp1 = ramp0;
  end

  // Never pass the target
  assign clamp = (dir_pos && (ramp1 > tgt_x)) || (dir_neg && (ramp1 < tgt_x));
  assign ramp2 = clamp ? tgt_x : ramp1;

  // Saturate to the signed 32-bit range
  always_comb begin
    if (ramp2 > SAT_MAX)      ramp_out = dvr_pkg::VEL_W'(SAT_MAX);
    else if (ramp2 < SAT_MIN) ramp_out = dvr_pkg::VEL_W'(SAT_MIN);
    else                      ramp_out = ramp2[dvr_pkg::VEL_W-1:0];
  end

endmodule

FILE: design/dual_axis_velocity_ramp.sv
// ---------------------------------------------------------------------------
// dual_axis_velocity_ramp - linear and angular velocity setpoint ramps
// Each transaction steps both ramped setpoints toward their targets with
// separate acceleration and deceleration limits per axis.
// ---------------------------------------------------------------------------
//  channel  direction  payload
//  in_      slave      tdata: lin_target, lin_measured, ang_target,
//                      ang_measured, tick_length; tuser: restart
//  out_     master     tdata: lin_ramped, ang_ramped
//  cfg_     slave      cfg_index (register), cfg_data (limit, low 31 bits)
//
//  One transaction per cycle sustained while the result is taken; input register,
//  then the axis step into the result register, which also holds the ramps.
//  Reset (rst_n low, synchronous) empties both registers and zeroes ramps
//  and limits. A stalled result holds while one more input is registered;
//  cfg_ready is always high.
// ---------------------------------------------------------------------------
module dual_axis_velocity_ramp (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] lin_target, [63:32] lin_measured, [95:64] ang_target,
  // [127:96] ang_measured, [143:128] tick_length
  input  logic [143:0]                    in_tdata,
  // [0] restart
  input  logic                            in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] lin_ramped, [63:32] ang_ramped
  output logic [63:0]                     out_tdata,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dvr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dvr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int VW = dvr_pkg::VEL_W;

  dvr_pkg::limits_t lin_limits, ang_limits;

  logic            s1_valid_r, s1_valid_nxt;
  logic [143:0]    s1_data_r;
  logic            s1_restart_r;
  logic            out_valid_r, out_valid_nxt;
  logic [63:0]     out_data_r;
  logic signed [VW-1:0] lin_ramp_r, ang_ramp_r;
  logic signed [VW-1:0] lin_base, ang_base, lin_new, ang_new;
  logic            advance, in_fire;

  // Limit registers
  dvr_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .lin_limits (lin_limits),
    .ang_limits (ang_limits)
  );

  // Handshake: result register moves when empty or taken
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)      s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  // Restart clears both ramps before the step
  assign lin_base = s1_restart_r ? '0 : lin_ramp_r;
  assign ang_base = s1_restart_r ? '0 : ang_ramp_r;

  dvr_axis u_lin (
    .tgt      (s1_data_r[31:0]),
    .meas     (s1_data_r[63:32]),
    .ramp     (lin_base),
    .limits   (lin_limits),
    .dt       (s1_data_r[143:128]),
    .ramp_out (lin_new)
  );

  dvr_axis u_ang (
    .tgt      (s1_data_r[95:64]),
    .meas     (s1_data_r[127:96]),
    .ramp     (ang_base),
    .limits   (ang_limits),
    .dt       (s1_data_r[143:128]),
    .ramp_out (ang_new)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lin_ramp_r  <= '0;
      ang_ramp_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance && s1_valid_r) begin
        lin_ramp_r <= lin_new;
        ang_ramp_r <= ang_new;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r    <= in_tdata;
      s1_restart_r <= in_tuser;
    end
    if (advance && s1_valid_r) begin
      out_data_r <= {ang_new, lin_new};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Assertions
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input not ready while result register empty");

  a_state_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_valid_r) |=> (out_tdata == {ang_ramp_r, lin_ramp_r}))
    else $error("ramp state differs from delivered result");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !s1_valid_r && lin_ramp_r == '0 && ang_ramp_r == '0))
    else $error("reset did not clear pipeline and ramps");

endmodule

FILE: test/dvr_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dvr_checker - setpoint predictor and result checker for the velocity ramp
// Watches the configuration, input and result channels. Each accepted input
// transaction steps a private copy of both axis ramps; the predicted
// setpoints are queued and compared field by field with the results in order.
// ---------------------------------------------------------------------------
module dvr_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // [31:0] lin_target, [63:32] lin_measured, [95:64] ang_target,
  // [127:96] ang_measured, [143:128] tick_length
  input  logic [143:0]                   in_tdata,
  // [0] restart
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] lin_ramped, [63:32] ang_ramped
  input  logic [63:0]                    out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dvr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dvr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             pending_count
);

  localparam longint VEL_MAX = 64'sd2147483647;
  localparam longint VEL_MIN = -64'sd2147483648;

  typedef struct {
    logic [dvr_pkg::VEL_W-1:0] lin;
    logic [dvr_pkg::VEL_W-1:0] ang;
  } setpoint_t;

  setpoint_t                 setpoint_q[$];
  dvr_pkg::limits_t          lin_lim;
  dvr_pkg::limits_t          ang_lim;
  logic [dvr_pkg::VEL_W-1:0] lin_ramp;
  logic [dvr_pkg::VEL_W-1:0] ang_ramp;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  function automatic int signum(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // One axis: jump to the measurement if it is ahead toward the target,
  // step by the accel or decel budget, never overshoot, then saturate.
  function automatic logic [dvr_pkg::VEL_W-1:0] ramp_axis(
    longint tgt, longint meas, longint ramp, longint acc, longint dec, longint dt);
    int     dir;
    longint delta;
    longint r;
    r = ramp;
    if (signum(meas - r) * signum(tgt - r) > 0)
      r = meas;
    dir = signum(tgt - meas);
    // speed magnitude growing (or starting from standstill) uses accel
    if (signum(meas) * dir >= 0)
      delta = (acc * dt) >>> 16;
    else
      delta = (dec * dt) >>> 16;
    r = r + longint'(dir) * delta;
    if (dir * signum(tgt - r) < 0)
      r = tgt;
    if (r > VEL_MAX)
      r = VEL_MAX;
    if (r < VEL_MIN)
      r = VEL_MIN;
    return r[dvr_pkg::VEL_W-1:0];
  endfunction

  always @(posedge clk) begin : monitor
    setpoint_t                 want;
    setpoint_t                 got;
    logic [dvr_pkg::VEL_W-1:0] lin_start;
    logic [dvr_pkg::VEL_W-1:0] ang_start;
    longint                    dt;
    if (!rst_n) begin
      setpoint_q.delete();
      lin_lim  = '0;
      ang_lim  = '0;
      lin_ramp = '0;
      ang_ramp = '0;
    end else begin
      // limit register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dvr_pkg::REG_LIN_ACCEL: lin_lim.accel = cfg_data[dvr_pkg::LIMIT_W-1:0];
          dvr_pkg::REG_LIN_DECEL: lin_lim.decel = cfg_data[dvr_pkg::LIMIT_W-1:0];
          dvr_pkg::REG_ANG_ACCEL: ang_lim.accel = cfg_data[dvr_pkg::LIMIT_W-1:0];
          dvr_pkg::REG_ANG_DECEL: ang_lim.decel = cfg_data[dvr_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end

      // result transactions against the oldest prediction
      if (out_tvalid && out_tready) begin
        got.lin = out_tdata[31:0];
        got.ang = out_tdata[63:32];
        if (setpoint_q.size() == 0) begin
          $display("%0t: unexpected result lin_ramped %h ang_ramped %h",
                   $time, got.lin, got.ang);
          mismatch_count++;
        end else begin
          want = setpoint_q.pop_front();
          if (got.lin !== want.lin) begin
            $display("%0t: lin_ramped expected %h actual %h", $time, want.lin, got.lin);
            mismatch_count++;
          end
          if (got.ang !== want.ang) begin
            $display("%0t: ang_ramped expected %h actual %h", $time, want.ang, got.ang);
            mismatch_count++;
          end
        end
      end

      // input transactions step both ramps
      if (in_tvalid && in_tready) begin
        lin_start = in_tuser ? '0 : lin_ramp;
        ang_start = in_tuser ? '0 : ang_ramp;
        dt = longint'(in_tdata[143:128]);
        lin_ramp = ramp_axis(longint'($signed(in_tdata[31:0])),
                             longint'($signed(in_tdata[63:32])),
                             longint'($signed(lin_start)),
                             longint'(lin_lim.accel), longint'(lin_lim.decel), dt);
        ang_ramp = ramp_axis(longint'($signed(in_tdata[95:64])),
                             longint'($signed(in_tdata[127:96])),
                             longint'($signed(ang_start)),
                             longint'(ang_lim.accel), longint'(ang_lim.decel), dt);
        want.lin = lin_ramp;
        want.ang = ang_ramp;
        setpoint_q.push_back(want);
      end
    end
    pending_count = setpoint_q.size();
  end

endmodule

FILE: test/dual_axis_velocity_ramp_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dual_axis_velocity_ramp_test - stimulus and verdict for the velocity ramp
// Drives directed corner ticks, then phases of random ticks under several
// limit settings and idling patterns, including a long result hold-off.
// Checking is done by dvr_checker alongside the block.
// ---------------------------------------------------------------------------
module dual_axis_velocity_ramp_test;

  localparam int     HOLD_CYCLES = 80;
  localparam int     QUIET_LIMIT = 3000;
  localparam int     PHASE_TICKS = 300;
  localparam logic [31:0] SPAN   = 32'h0004_0000;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [143:0]                   in_tdata   = '0;
  logic                           in_tuser   = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [63:0]                    out_tdata;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [dvr_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [dvr_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  int          mismatch_count;
  int          pending_count;
  int          send_idle_pct = 0;
  int          rcv_stall_pct = 0;
  logic        hold_req      = 1'b0;
  int          hold_left     = 0;
  int          quiet_cycles  = 0;
  logic [31:0] lin_hold      = '0;
  logic [31:0] ang_hold      = '0;

  dual_axis_velocity_ramp u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  dvr_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, plus a counted hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else if (++quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // register write; cfg_valid stays high for a following write
  task automatic write_reg(input logic [dvr_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_limits(input logic [31:0] la, input logic [31:0] ld,
                            input logic [31:0] aa, input logic [31:0] ad);
    write_reg(dvr_pkg::REG_LIN_ACCEL, la);
    write_reg(dvr_pkg::REG_LIN_DECEL, ld);
    write_reg(dvr_pkg::REG_ANG_ACCEL, aa);
    write_reg(dvr_pkg::REG_ANG_DECEL, ad);
    cfg_valid = 1'b0;
  endtask

  // one input transaction, after an optional random gap
  task automatic offer_tick(input logic [31:0] lt, input logic [31:0] lm,
                            input logic [31:0] at, input logic [31:0] am,
                            input logic [15:0] dt, input logic rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata  = 144'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {dt, am, at, lm, lt};
    in_tuser  = rs;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // block fully drained, then the pipeline is left to settle
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] near_vel(input logic [31:0] base);
    case ($urandom_range(9))
      0: return $urandom();
      1: case ($urandom_range(2))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           default: return 32'h0;
         endcase
      2: return base;
      3: return 32'h0;
      default: return base + $urandom_range(0, 2 * SPAN) - SPAN;
    endcase
  endfunction

  function automatic logic [31:0] new_hold();
    if ($urandom_range(3) == 0)
      return $urandom();
    return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return {1'($urandom_range(1)), 7'h0, 24'($urandom_range(0, 32'h0040_0000))};
    endcase
  endfunction

  // targets mostly held over several ticks so the ramps get to travel
  task automatic random_tick();
    logic [31:0] lt;
    logic [31:0] at;
    logic [15:0] dt;
    if ($urandom_range(99) < 12) lin_hold = new_hold();
    if ($urandom_range(99) < 12) ang_hold = new_hold();
    lt = ($urandom_range(4) == 0) ? near_vel(lin_hold) : lin_hold;
    at = ($urandom_range(4) == 0) ? near_vel(ang_hold) : ang_hold;
    case ($urandom_range(7))
      0: dt = 16'h0;
      1: dt = 16'hFFFF;
      2: dt = 16'($urandom());
      default: dt = 16'($urandom_range(1, 16'h0800));
    endcase
    offer_tick(lt, near_vel(lt), at, near_vel(at), dt, $urandom_range(19) == 0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int ticks,
                           input logic pressure);
    send_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
    for (int i = 0; i < ticks; i++) begin
      if (pressure && (i % 100 == 0))
        hold_req = 1'b1;
      random_tick();
    end
    drain();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: moderate limits, decel stronger than accel
    set_limits(32'h0005_0000, 32'h000A_0000, 32'h0002_0000, 32'h0003_0000);
    offer_tick(32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0);
    offer_tick(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000, 16'h1000, 1'b0);
    offer_tick(32'h0010_0000, 32'h0, 32'hFFF0_0000, 32'h0, 16'h8000, 1'b0);
    offer_tick(32'h0010_0000, 32'h0, 32'hFFF0_0000, 32'h0, 16'h8000, 1'b0);
    offer_tick(32'h0010_0000, 32'h000C_0000, 32'hFFF0_0000, 32'hFFF4_0000, 16'h8000, 1'b0);
    offer_tick(32'h0, 32'h0010_0000, 32'h0, 32'hFFF0_0000, 16'h4000, 1'b0);
    offer_tick(32'hFFF0_0000, 32'h0008_0000, 32'h0010_0000, 32'hFFF8_0000, 16'h4000, 1'b0);
    offer_tick(32'hFFF0_0000, 32'h0008_0000, 32'h0010_0000, 32'hFFF8_0000, 16'h4000, 1'b1);
    offer_tick(32'h4000_0000, 32'h0, 32'hC000_0000, 32'h0, 16'hFFFF, 1'b0);
    drain();

    // directed: largest limits against the extremes of the velocity range
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    offer_tick(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    offer_tick(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 16'hFFFF, 1'b1);
    offer_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0);
    offer_tick(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0001, 32'h8000_0000, 16'h0001, 1'b0);
    drain();

    // directed: zero limits, only the snap to the measurement moves the ramp
    set_limits(32'h0, 32'h0, 32'h0, 32'h0);
    offer_tick(32'h0010_0000, 32'h0, 32'hFFF0_0000, 32'h0, 16'hFFFF, 1'b0);
    offer_tick(32'h0010_0000, 32'h0008_0000, 32'hFFF0_0000, 32'hFFF8_0000, 16'hFFFF, 1'b0);
    offer_tick(32'h0, 32'h0008_0000, 32'h0, 32'hFFF8_0000, 16'hFFFF, 1'b0);
    drain();

    // random phases with differing limits and idling
    set_limits(pick_limit(), pick_limit(), pick_limit(), pick_limit());
    run_phase(0, 0, PHASE_TICKS, 1'b0);
    set_limits(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    run_phase(68, 0, PHASE_TICKS, 1'b0);
    set_limits(32'h0, 32'h0, 32'h0, 32'h0);
    run_phase(0, 68, PHASE_TICKS, 1'b0);
    set_limits(32'h0001_0000, 32'h0008_0000, 32'h0003_0000, 32'h0000_8000);
    run_phase(27, 27, PHASE_TICKS, 1'b0);
    set_limits($urandom(), $urandom(), $urandom(), $urandom());
    run_phase(0, 0, PHASE_TICKS, 1'b1);
    set_limits(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF);
    run_phase(0, 0, PHASE_TICKS, 1'b0);

    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
